/* rtl/core/bnv_pkg.sv */
package bnv_pkg;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       end_of_frame;
  } out_pixel_t;

  typedef struct packed {
    logic [8:0] sum_r;
    logic [8:0] sum_g;
    logic [8:0] sum_b;
  } pair_sum_t;

  typedef struct packed {
    in_pixel_t pixel;
    pair_sum_t pair;
    logic      chroma;
    logic      eof;
  } stage_t;

  function automatic logic [7:0] luma_sat(input logic [16:0] acc);
    logic [9:0] t;
    t = 10'(acc[16:8]) + 10'd16;
    if (t > 10'd255) begin
      return 8'd255;
    end
    return t[7:0];
  endfunction

  function automatic logic [7:0] chroma_sat(input logic signed [17:0] acc);
    logic signed [18:0] biased;
    biased = 19'(acc) + 19'sd32768;
    if (biased < 19'sd0) begin
      return 8'd0;
    end
    if (biased[18:8] > 11'd255) begin
      return 8'd255;
    end
    return biased[15:8];
  endfunction

endpackage

/* rtl/core/bnv_line_buf.sv */
module bnv_line_buf #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  bnv_pkg::pair_sum_t   wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output bnv_pkg::pair_sum_t   rd_data
);

  bnv_pkg::pair_sum_t mem [DEPTH];
  bnv_pkg::pair_sum_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/bnv_csc.sv */
module bnv_csc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 st_valid,
  input  bnv_pkg::stage_t      st,
  input  bnv_pkg::pair_sum_t   line_sum,
  output logic                 st_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bnv_pkg::out_pixel_t  out_data
);

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  bnv_pkg::out_pixel_t  out_data_r;
  bnv_pkg::out_pixel_t  out_data_nxt;
  logic [16:0]          y_acc;
  logic [9:0]           tot_b;
  logic [9:0]           tot_g;
  logic [9:0]           tot_r;
  logic signed [17:0]   avg_b;
  logic signed [17:0]   avg_g;
  logic signed [17:0]   avg_r;
  logic signed [17:0]   u_acc;
  logic signed [17:0]   v_acc;

  assign st_ready = !out_valid_r || out_ready;

  always_comb begin
    y_acc = 17'(st.pixel.red) * 17'd66 + 17'(st.pixel.green) * 17'd129
          + 17'(st.pixel.blue) * 17'd25 + 17'd128;
    tot_b = 10'(st.pair.sum_b) + 10'(line_sum.sum_b);
    tot_g = 10'(st.pair.sum_g) + 10'(line_sum.sum_g);
    tot_r = 10'(st.pair.sum_r) + 10'(line_sum.sum_r);
    avg_b = $signed(18'(tot_b[9:2]));
    avg_g = $signed(18'(tot_g[9:2]));
    avg_r = $signed(18'(tot_r[9:2]));
    u_acc = 18'sd112 * avg_b - 18'sd74 * avg_g - 18'sd38 * avg_r + 18'sd128;
    v_acc = 18'sd112 * avg_r - 18'sd94 * avg_g - 18'sd18 * avg_b + 18'sd128;

    out_data_nxt.luma         = bnv_pkg::luma_sat(y_acc);
    out_data_nxt.chroma_valid = st.chroma;
    out_data_nxt.chroma_u     = st.chroma ? bnv_pkg::chroma_sat(u_acc) : 8'd0;
    out_data_nxt.chroma_v     = st.chroma ? bnv_pkg::chroma_sat(v_acc) : 8'd0;
    out_data_nxt.end_of_frame = st.eof;

    out_valid_nxt = out_valid_r;
    if (st_ready) begin
      out_valid_nxt = st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (st_ready && st_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/bgra_to_nv12_converter.sv */
// Accepted inputs pass the stage register, then the output register in bnv_csc.
// Throughput: one pixel per cycle unless out_ready is low; line buffer port and color math keep pace.
// Reset is synchronous and active low; it restores the default frame size of 1920 by 1080
// and clears the position counters and all valid flags. The line buffer needs no clearing.
module bgra_to_nv12_converter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bnv_pkg::in_pixel_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bnv_pkg::out_pixel_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bnv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bnv_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int SW         = bnv_pkg::CFG_DATA_W + 1;

  logic [bnv_pkg::CFG_DATA_W-1:0] frame_width_r;
  logic [bnv_pkg::CFG_DATA_W-1:0] frame_height_r;
  logic [CW-1:0]                  col_r;
  logic [CW-1:0]                  col_nxt;
  logic [RW-1:0]                  row_r;
  logic [RW-1:0]                  row_nxt;
  bnv_pkg::in_pixel_t             hold_r;
  logic                           st_valid_r;
  bnv_pkg::stage_t                st_r;
  bnv_pkg::stage_t                st_nxt;
  logic                           st_ready;
  logic                           in_acc;
  logic [SW-1:0]                  eff_w;
  logic [SW-1:0]                  eff_h;
  logic [SW-1:0]                  col_inc;
  logic [SW-1:0]                  row_inc;
  logic                           eof;
  logic [AW-1:0]                  line_addr;
  bnv_pkg::pair_sum_t             pair;
  bnv_pkg::pair_sum_t             line_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = !st_valid_r || st_ready;
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = SW'(1);
    end else if (SW'(frame_width_r) > SW'(MAX_WIDTH)) begin
      eff_w = SW'(MAX_WIDTH);
    end else begin
      eff_w = SW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_h = SW'(1);
    end else if (SW'(frame_height_r) > SW'(MAX_HEIGHT)) begin
      eff_h = SW'(MAX_HEIGHT);
    end else begin
      eff_h = SW'(frame_height_r);
    end

    col_inc = SW'(col_r) + SW'(1);
    row_inc = SW'(row_r) + SW'(1);
    eof     = 1'b0;
    row_nxt = row_r;
    col_nxt = col_inc[CW-1:0];
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = row_inc[RW-1:0];
      if (row_inc >= eff_h) begin
        row_nxt = '0;
        eof     = 1'b1;
      end
    end

    pair.sum_b = 9'(in_data.blue) + 9'(hold_r.blue);
    pair.sum_g = 9'(in_data.green) + 9'(hold_r.green);
    pair.sum_r = 9'(in_data.red) + 9'(hold_r.red);
    line_addr  = AW'(col_r >> 1);

    st_nxt.pixel  = in_data;
    st_nxt.pair   = pair;
    st_nxt.chroma = col_r[0] && row_r[0];
    st_nxt.eof    = eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bnv_pkg::FRAME_WIDTH_RST;
      frame_height_r <= bnv_pkg::FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
      hold_r         <= '0;
      st_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bnv_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          bnv_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        if (!col_r[0]) begin
          hold_r <= in_data;
        end
        st_valid_r <= 1'b1;
      end else if (st_ready) begin
        st_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  bnv_line_buf #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (in_acc && col_r[0] && !row_r[0]),
    .wr_addr (line_addr),
    .wr_data (pair),
    .rd_en   (in_acc && col_r[0] && row_r[0]),
    .rd_addr (line_addr),
    .rd_data (line_sum)
  );

  bnv_csc u_csc (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_valid  (st_valid_r),
    .st        (st_r),
    .line_sum  (line_sum),
    .st_ready  (st_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/bnv_checker.sv */
module bnv_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input bnv_pkg::out_pixel_t  out_data
);

  // A stalled output transaction keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // Chroma fields are zero whenever no 2x2 block completes.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.chroma_valid |-> out_data.chroma_u == 8'd0
      && out_data.chroma_v == 8'd0)
    else $error("chroma fields nonzero without a completed block");

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bgra_to_nv12_converter bnv_checker u_bnv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
